// ===== rtl/hpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, stage structs and saturation helper for the Horner evaluator.
// No dependencies; imported by every module under rtl/.
package hpe_pkg;

    localparam int DEGREE      = 7;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int NUM_COEFFS  = 8;
    localparam int CFG_IDX_W   = $clog2(NUM_COEFFS);

    // Half an LSB of the result, zero when there are no fraction bits.
    localparam logic signed [PROD_W-1:0] ROUND_K =
        PROD_W'((64'sd1 <<< FRAC_BITS) >>> 1);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [NUM_COEFFS-1:0][DATA_W-1:0] t_coeff_arr;

    // Running accumulator between Horner steps.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } t_acc_stage;

    // Full product after the multiplier register.
    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] x;
        logic                     ovf;
    } t_prod_stage;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } t_sat;

    // Clamp a wide signed value to DATA_W bits.
    function automatic t_sat sat_wide(input logic signed [PROD_W-1:0] v);
        t_sat res;
        logic in_range;
        in_range = (&v[PROD_W-1:DATA_W-1]) || (~|v[PROD_W-1:DATA_W-1]);
        res.ovf  = ~in_range;
        if (in_range) begin
            res.val = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            res.val = SAT_MIN;
        end else begin
            res.val = SAT_MAX;
        end
        return res;
    endfunction

endpackage

// ===== rtl/hpe_coeff_regs.sv =====
`timescale 1ns / 1ps
// Coefficient register file, written through the plain config port.
// Depends on hpe_pkg.
module hpe_coeff_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [hpe_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [hpe_pkg::DATA_W-1:0]       i_cfg_wdata,
    output hpe_pkg::t_coeff_arr              o_coeff
);
    import hpe_pkg::*;

    t_coeff_arr r_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= '0;
        end else if (i_cfg_wr_en) begin
            r_coeff[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    assign o_coeff = r_coeff;

endmodule

// ===== rtl/hpe_mul_stage.sv =====
`timescale 1ns / 1ps
// First half of a Horner step: registered full product acc * x.
// Depends on hpe_pkg.
module hpe_mul_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hpe_pkg::t_acc_stage  i_in,
    output logic                 o_in_ready,
    output hpe_pkg::t_prod_stage o_out,
    input  logic                 i_out_ready
);
    import hpe_pkg::*;

    logic                     r_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_x;
    logic                     r_ovf;
    logic signed [PROD_W-1:0] n_prod;

    // stage moves when empty or when downstream takes its item
    assign o_in_ready = !r_valid || i_out_ready;
    assign n_prod     = $signed(i_in.acc) * $signed(i_in.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in.valid) begin
            r_prod <= n_prod;
            r_x    <= i_in.x;
            r_ovf  <= i_in.ovf;
        end
    end

    always_comb begin
        o_out.valid = r_valid;
        o_out.prod  = r_prod;
        o_out.x     = r_x;
        o_out.ovf   = r_ovf;
    end

endmodule

// ===== rtl/hpe_add_stage.sv =====
`timescale 1ns / 1ps
// Second half of a Horner step: round, saturate, add coefficient, saturate.
// Depends on hpe_pkg.
module hpe_add_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hpe_pkg::t_prod_stage             i_in,
    input  logic signed [hpe_pkg::DATA_W-1:0] i_coeff,
    output logic                             o_in_ready,
    output hpe_pkg::t_acc_stage              o_out,
    input  logic                             i_out_ready
);
    import hpe_pkg::*;

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_x;
    logic                     r_ovf;
    logic signed [PROD_W-1:0] n_shift;
    logic signed [PROD_W-1:0] n_sum;
    t_sat                     n_rnd;
    t_sat                     n_acc;

    assign o_in_ready = !r_valid || i_out_ready;

    always_comb begin
        // round half up: add half LSB, then floor via arithmetic shift
        n_shift = (i_in.prod + ROUND_K) >>> FRAC_BITS;
        n_rnd   = sat_wide(n_shift);
        n_sum   = PROD_W'(n_rnd.val) + PROD_W'(i_coeff);
        n_acc   = sat_wide(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in.valid) begin
            r_acc <= n_acc.val;
            r_x   <= i_in.x;
            r_ovf <= i_in.ovf | n_rnd.ovf | n_acc.ovf;
        end
    end

    always_comb begin
        o_out.valid = r_valid;
        o_out.acc   = r_acc;
        o_out.x     = r_x;
        o_out.ovf   = r_ovf;
    end

endmodule

// ===== rtl/horner_polynomial_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the Horner polynomial evaluator (signed Q16.16, degree 7).
// Depends on hpe_pkg, hpe_coeff_regs, hpe_mul_stage, hpe_add_stage.
//
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------
//  s_axis   | in        | tdata[31:0] = x_value
//  m_axis   | out       | tdata[31:0] = poly_value, tuser[0] = overflow
//  cfg      | in        | addr 0..7 selects coeff_0..coeff_7, wdata 32 bit
//
// One item per cycle sustained while m_axis is ready. Each Horner step is a
// multiplier register followed by a round/add/saturate register.
// Synchronous active-low reset empties the pipeline and zeroes coefficients.
// Every stage has its own valid bit and ready, so bubbles are squeezed out
// under backpressure and a stalled item is held, never dropped or repeated.
// Coefficients are read live by every step; write them only while idle.
module horner_polynomial_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream: x_value
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [hpe_pkg::DATA_W-1:0]    i_s_axis_tdata,   // [31:0] x_value
    // master stream: result
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [hpe_pkg::DATA_W-1:0]    o_m_axis_tdata,   // [31:0] poly_value
    output logic                          o_m_axis_tuser,   // [0] overflow
    // config write port
    input  logic                          i_cfg_wr_en,
    input  logic [hpe_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [hpe_pkg::DATA_W-1:0]    i_cfg_wdata
);
    import hpe_pkg::*;

    t_coeff_arr  w_coeff;
    t_acc_stage  w_acc  [DEGREE+1];   // [0] is the input, [DEGREE] the output reg
    logic        w_acc_rdy [DEGREE+1];
    t_prod_stage w_prod [DEGREE];
    logic        w_prod_rdy [DEGREE];
    logic [2*DEGREE-1:0] w_valid;     // all stage valid bits, for checks

    hpe_coeff_regs u_coeff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coeff     (w_coeff)
    );

    // Horner seed: acc = leading coefficient
    always_comb begin
        w_acc[0].valid = i_s_axis_tvalid;
        w_acc[0].acc   = w_coeff[DEGREE];
        w_acc[0].x     = i_s_axis_tdata;
        w_acc[0].ovf   = 1'b0;
    end

    assign o_s_axis_tready   = w_acc_rdy[0];
    assign w_acc_rdy[DEGREE] = i_m_axis_tready;

    for (genvar j = 0; j < DEGREE; j++) begin : g_step
        hpe_mul_stage u_mul (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in        (w_acc[j]),
            .o_in_ready  (w_acc_rdy[j]),
            .o_out       (w_prod[j]),
            .i_out_ready (w_prod_rdy[j])
        );

        // step j folds in coeff_(DEGREE-1-j)
        hpe_add_stage u_add (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in        (w_prod[j]),
            .i_coeff     (w_coeff[DEGREE-1-j]),
            .o_in_ready  (w_prod_rdy[j]),
            .o_out       (w_acc[j+1]),
            .i_out_ready (w_acc_rdy[j+1])
        );

        assign w_valid[2*j]   = w_prod[j].valid;
        assign w_valid[2*j+1] = w_acc[j+1].valid;
    end

    assign o_m_axis_tvalid = w_acc[DEGREE].valid;
    assign o_m_axis_tdata  = w_acc[DEGREE].acc;
    assign o_m_axis_tuser  = w_acc[DEGREE].ovf;

    // input can only be refused when every stage is full and the sink stalls
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> ((&w_valid) && !i_m_axis_tready))
        else $error("input stalled while pipeline has room");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (w_valid == '0))
        else $error("stage valid set right after reset");

    // a blocked first-step product keeps its item
    a_prod_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_prod[0].valid && !w_prod_rdy[0]) |=>
            (w_prod[0].valid && $stable(w_prod[0].prod) && $stable(w_prod[0].x)))
        else $error("stalled product changed");

endmodule
